[rtl/owsc_pkg.sv]
`default_nettype none
package owsc_pkg;

   localparam int unsigned STAGES = 7;

   localparam int unsigned IN_W    = 16;
   localparam int unsigned SPEED_W = 38;
   localparam int unsigned MAG_W   = 33;
   localparam int unsigned INV_W   = 30;
   localparam int unsigned PROD_W  = MAG_W + INV_W;
   localparam int unsigned X_W     = 26;
   localparam int unsigned T1_W    = 24;
   localparam int unsigned T2_W    = 25;
   localparam int unsigned T3_W    = 26;
   localparam int unsigned FRAC_W  = 24;
   localparam int unsigned SERVO_W = 8;

   localparam logic signed [SPEED_W-1:0] K_SPIN    = 38'sd1179648;
   localparam logic signed [SPEED_W-1:0] K_ONE_X   = -38'sd819200;
   localparam logic signed [SPEED_W-1:0] K_TWO_X   = 38'sd409600;
   localparam logic signed [SPEED_W-1:0] K_TWO_Y   = -38'sd709450;
   localparam logic signed [SPEED_W-1:0] K_THREE_X = 38'sd709450;
   localparam logic signed [SPEED_W-1:0] K_THREE_Y = 38'sd409600;

   localparam logic signed [SPEED_W-1:0] LIMIT     = 38'sd6442450944;
   localparam logic signed [SPEED_W-1:0] NEG_LIMIT = -38'sd6442450944;

   localparam logic [INV_W-1:0] INV_TWO_PI = 30'd683565276;

   localparam logic signed [T1_W-1:0] PC3 = 24'sd2608680;
   localparam logic signed [T1_W-1:0] PC2 = 24'sd826298;
   localparam logic signed [T2_W-1:0] PC1 = 25'sd1449637;
   localparam logic signed [T3_W-1:0] PC0 = 26'sd8416539;

   localparam logic [SERVO_W-1:0] SERVO_MAX = 8'd255;

endpackage
`default_nettype wire

[rtl/owsc_ifs.sv]
`default_nettype none
interface owsc_req_if;
   logic                valid;
   logic                ready;
   logic signed [15:0]  vel_x;
   logic signed [15:0]  vel_y;
   logic signed [15:0]  body_rate;

   modport source (output valid, output vel_x, output vel_y, output body_rate, input ready);
   modport sink   (input valid, input vel_x, input vel_y, input body_rate, output ready);
endinterface

interface owsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  servo_one;
   logic [7:0]  servo_two;
   logic [7:0]  servo_three;
   logic        limit_error;

   modport source (output valid, output servo_one, output servo_two, output servo_three,
                   output limit_error, input ready);
   modport sink   (input valid, input servo_one, input servo_two, input servo_three,
                   input limit_error, output ready);
endinterface
`default_nettype wire

[rtl/owsc_kin.sv]
`default_nettype none
module owsc_kin (
   input  wire logic                                 clock,
   input  wire logic                                 en,
   input  wire logic signed [owsc_pkg::IN_W-1:0]     vel_x,
   input  wire logic signed [owsc_pkg::IN_W-1:0]     vel_y,
   input  wire logic signed [owsc_pkg::IN_W-1:0]     body_rate,
   output logic signed [owsc_pkg::SPEED_W-1:0]       speed_one,
   output logic signed [owsc_pkg::SPEED_W-1:0]       speed_two,
   output logic signed [owsc_pkg::SPEED_W-1:0]       speed_three
);
   logic signed [owsc_pkg::SPEED_W-1:0] vx, vy, om, spin;
   logic signed [owsc_pkg::SPEED_W-1:0] one_in, two_in, three_in;
   logic signed [owsc_pkg::SPEED_W-1:0] one_ff, two_ff, three_ff;

   always_comb begin
      vx       = owsc_pkg::SPEED_W'(vel_x);
      vy       = owsc_pkg::SPEED_W'(vel_y);
      om       = owsc_pkg::SPEED_W'(body_rate);
      spin     = om * owsc_pkg::K_SPIN;
      one_in   = vx * owsc_pkg::K_ONE_X + spin;
      two_in   = vx * owsc_pkg::K_TWO_X + vy * owsc_pkg::K_TWO_Y + spin;
      three_in = vx * owsc_pkg::K_THREE_X + vy * owsc_pkg::K_THREE_Y + spin;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         one_ff   <= one_in;
         two_ff   <= two_in;
         three_ff <= three_in;
      end
   end

   assign speed_one   = one_ff;
   assign speed_two   = two_ff;
   assign speed_three = three_ff;
endmodule
`default_nettype wire

[rtl/owsc_wheel.sv]
`default_nettype none
module owsc_wheel (
   input  wire logic                                  clock,
   input  wire logic [owsc_pkg::STAGES-2:0]           en,
   input  wire logic signed [owsc_pkg::SPEED_W-1:0]   speed,
   output logic [owsc_pkg::SERVO_W-1:0]               servo
);
   localparam int unsigned S_W = owsc_pkg::T3_W - 16;

   logic                                zero_ff [1:5];
   logic [owsc_pkg::MAG_W-1:0]          mag_in, mag_ff;
   logic                                neg_ff;
   logic [owsc_pkg::PROD_W-1:0]         prod;
   logic [owsc_pkg::FRAC_W:0]           xmag;
   logic signed [owsc_pkg::X_W-1:0]     x_in;
   logic signed [owsc_pkg::X_W-1:0]     x_ff [3:5];
   logic signed [47:0]                  m1;
   logic signed [49:0]                  m2;
   logic signed [51:0]                  m3;
   logic signed [owsc_pkg::T1_W-1:0]    t1_in, t1_ff;
   logic signed [owsc_pkg::T2_W-1:0]    t2_in, t2_ff;
   logic signed [owsc_pkg::T3_W-1:0]    t3_in, t3_ff;
   logic signed [S_W-1:0]               s;
   logic [owsc_pkg::SERVO_W-1:0]        servo_in, servo_ff;

   always_comb begin
      mag_in = speed[owsc_pkg::SPEED_W-1] ? owsc_pkg::MAG_W'(-speed)
                                          : owsc_pkg::MAG_W'(speed);
      prod   = owsc_pkg::PROD_W'(mag_ff) * owsc_pkg::PROD_W'(owsc_pkg::INV_TWO_PI);
      xmag   = prod[owsc_pkg::PROD_W-1:38];
      x_in   = neg_ff ? -owsc_pkg::X_W'(signed'({1'b0, xmag}))
                      : owsc_pkg::X_W'(signed'({1'b0, xmag}));
      m1     = 48'(owsc_pkg::PC3) * 48'(x_ff[3]);
      t1_in  = owsc_pkg::T1_W'(m1 >>> owsc_pkg::FRAC_W) - owsc_pkg::PC2;
      m2     = 50'(t1_ff) * 50'(x_ff[4]);
      t2_in  = owsc_pkg::T2_W'(m2 >>> owsc_pkg::FRAC_W) + owsc_pkg::PC1;
      m3     = 52'(t2_ff) * 52'(x_ff[5]);
      t3_in  = owsc_pkg::T3_W'(m3 >>> owsc_pkg::FRAC_W) + owsc_pkg::PC0;
      s      = S_W'(t3_ff >>> 16);
      if (zero_ff[5] || s < 0) begin
         servo_in = '0;
      end else if (s > signed'(S_W'(owsc_pkg::SERVO_MAX))) begin
         servo_in = owsc_pkg::SERVO_MAX;
      end else begin
         servo_in = owsc_pkg::SERVO_W'(s);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mag_ff     <= mag_in;
         neg_ff     <= speed[owsc_pkg::SPEED_W-1];
         zero_ff[1] <= (speed >= owsc_pkg::LIMIT) || (speed <= owsc_pkg::NEG_LIMIT);
      end
      if (en[1]) begin
         x_ff[3]    <= x_in;
         zero_ff[2] <= zero_ff[1];
      end
      if (en[2]) begin
         t1_ff      <= t1_in;
         x_ff[4]    <= x_ff[3];
         zero_ff[3] <= zero_ff[2];
      end
      if (en[3]) begin
         t2_ff      <= t2_in;
         x_ff[5]    <= x_ff[4];
         zero_ff[4] <= zero_ff[3];
      end
      if (en[4]) begin
         t3_ff      <= t3_in;
         zero_ff[5] <= zero_ff[4];
      end
      if (en[5]) begin
         servo_ff   <= servo_in;
      end
   end

   assign servo = servo_ff;
endmodule
`default_nettype wire

[rtl/omni_wheel_servo_command_unit.sv]
// An accepted request is registered in the kinematics stage and then in each wheel's stages.
// Throughput: one request per cycle while the output is not stalled; the pipeline holds up to 7 requests in flight.
// A stalled output backs up only the stages behind it, so bubbles are absorbed.
// Reset is synchronous and active high; it clears the stage valid bits only.
`default_nettype none
module omni_wheel_servo_command_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   owsc_req_if.sink   req,
   owsc_rsp_if.source rsp
);
   localparam int unsigned N = owsc_pkg::STAGES;

   logic [N-1:0]                          valid_ff;
   logic [N-1:0]                          en;
   logic [N-1:1]                          err_ff;
   logic                                  err_in;
   logic signed [owsc_pkg::SPEED_W-1:0]   w_one, w_two, w_three;
   logic [owsc_pkg::SERVO_W-1:0]          s_one, s_two, s_three;

   always_comb begin
      en[N-1] = !valid_ff[N-1] || rsp.ready;
      for (int k = N - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      err_in = (w_one > owsc_pkg::LIMIT) || (w_one < owsc_pkg::NEG_LIMIT) ||
               (w_two > owsc_pkg::LIMIT) || (w_two < owsc_pkg::NEG_LIMIT) ||
               (w_three > owsc_pkg::LIMIT) || (w_three < owsc_pkg::NEG_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req.valid;
         end
         for (int k = 1; k < N; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         err_ff[1] <= err_in;
      end
      for (int k = 2; k < N; k++) begin
         if (en[k]) begin
            err_ff[k] <= err_ff[k-1];
         end
      end
   end

   owsc_kin u_kin (
      .clock       (clock),
      .en          (en[0]),
      .vel_x       (req.vel_x),
      .vel_y       (req.vel_y),
      .body_rate   (req.body_rate),
      .speed_one   (w_one),
      .speed_two   (w_two),
      .speed_three (w_three)
   );

   owsc_wheel u_wheel_one (
      .clock (clock),
      .en    (en[N-1:1]),
      .speed (w_one),
      .servo (s_one)
   );

   owsc_wheel u_wheel_two (
      .clock (clock),
      .en    (en[N-1:1]),
      .speed (w_two),
      .servo (s_two)
   );

   owsc_wheel u_wheel_three (
      .clock (clock),
      .en    (en[N-1:1]),
      .speed (w_three),
      .servo (s_three)
   );

   assign req.ready       = en[0];
   assign rsp.valid       = valid_ff[N-1];
   assign rsp.limit_error = err_ff[N-1];
   assign rsp.servo_one   = err_ff[N-1] ? '0 : s_one;
   assign rsp.servo_two   = err_ff[N-1] ? '0 : s_two;
   assign rsp.servo_three = err_ff[N-1] ? '0 : s_three;
endmodule
`default_nettype wire

[rtl/owsc_checker.sv]
`default_nettype none
module owsc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  servo_one,
   input wire logic [7:0]  servo_two,
   input wire logic [7:0]  servo_three,
   input wire logic        limit_error
);
   // A result flagged as over the limit carries no servo commands.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && limit_error |-> servo_one == 8'd0 && servo_two == 8'd0 &&
                                   servo_three == 8'd0)
      else $error("limit error with nonzero servo command");

   // A result that is not taken stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(servo_one) && $stable(servo_two) &&
                                  $stable(servo_three) && $stable(limit_error))
      else $error("stalled result changed");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // When the output can move, nothing inside may hold back a new request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request refused while the output drains");
endmodule

bind omni_wheel_servo_command_unit owsc_checker u_owsc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .servo_one   (rsp.servo_one),
   .servo_two   (rsp.servo_two),
   .servo_three (rsp.servo_three),
   .limit_error (rsp.limit_error)
);
`default_nettype wire
